// File: hw/rtl/idwtpc_pkg.sv
// ----------------------------------------------------------------------------
// idwtpc_pkg
// Shared constants, codes and types of the grid position correction block.
// ----------------------------------------------------------------------------
package idwtpc_pkg;

  localparam int GRID_COLS = 32;
  localparam int GRID_ROWS = 32;
  localparam int COL_W     = 5;
  localparam int ROW_W     = 5;
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int DEPTH     = GRID_COLS * GRID_ROWS;

  localparam int POS_W   = 24;
  localparam int CW_W    = 23;
  localparam int CELL_W  = 26;
  localparam int SQ_W    = 50;
  localparam int DIST_W  = 51;
  localparam int REM_W   = 52;
  localparam int QUO_W   = 32;
  localparam int NUM_W   = 24;
  localparam int CNT_W   = 6;
  localparam int WGT_W   = 33;
  localparam int WSUM_W  = 35;
  localparam int ACC_W   = 59;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 68;
  localparam int DATA_W  = 2 * POS_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  localparam logic signed [POS_W-1:0] GRID_MIN_RST   = -24'sd524288;
  localparam logic signed [POS_W-1:0] GRID_MAX_RST   = 24'sd524288;
  localparam logic [CW_W-1:0]         CELL_WIDTH_RST = 23'd32768;

  localparam logic [CNT_W-1:0] ITERS_POS   = 6'd24;
  localparam logic [CNT_W-1:0] ITERS_RATIO = 6'd32;
  localparam logic [WGT_W-1:0] WGT_ONE     = 33'h1_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_DIVX, S_DIVY, S_SQ, S_DSUM, S_READ, S_WSTART,
    S_WDIV, S_WSQ, S_WSQR, S_MX, S_MY, S_MYR, S_QX, S_QY_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: hw/rtl/idwtpc_table_ram.sv
// ----------------------------------------------------------------------------
// idwtpc_table_ram
// Correction table memory: x and y values side by side, one registered read.
// ----------------------------------------------------------------------------
module idwtpc_table_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [idwtpc_pkg::ADDR_W-1:0]     waddr,
  input  logic [idwtpc_pkg::DATA_W-1:0]     wdata,
  input  logic [idwtpc_pkg::ADDR_W-1:0]     raddr,
  output logic [idwtpc_pkg::DATA_W-1:0]     rdata
);

  logic [idwtpc_pkg::DATA_W-1:0] mem [idwtpc_pkg::DEPTH];
  logic [idwtpc_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/idwtpc_divider.sv
// ----------------------------------------------------------------------------
// idwtpc_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idwtpc_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  idwtpc_pkg::div_ctl_t              ctl,
  input  logic [idwtpc_pkg::REM_W-1:0]      r_init,
  input  logic [idwtpc_pkg::DIST_W-1:0]     den,
  input  logic [idwtpc_pkg::NUM_W-1:0]      num_init,
  output idwtpc_pkg::div_sts_t              sts,
  output logic [idwtpc_pkg::QUO_W-1:0]      quo,
  output logic [idwtpc_pkg::REM_W-1:0]      rem
);

  logic [idwtpc_pkg::REM_W-1:0]  rem_r;
  logic [idwtpc_pkg::DIST_W-1:0] den_r;
  logic [idwtpc_pkg::NUM_W-1:0]  num_r;
  logic [idwtpc_pkg::QUO_W-1:0]  quo_r;
  logic [idwtpc_pkg::CNT_W-1:0]  cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [idwtpc_pkg::REM_W-1:0]  trial;
  logic                          fits;

  assign trial = {rem_r[idwtpc_pkg::REM_W-2:0], num_r[idwtpc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= ctl.iters;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != 6'd1);
      done_r <= (cnt_r == 6'd1);
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= r_init;
      den_r <= den;
      num_r <= num_init;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
      num_r <= {num_r[idwtpc_pkg::NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[idwtpc_pkg::QUO_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;
  assign rem      = rem_r;

endmodule

// File: hw/rtl/idw_table_position_correction.sv
// ----------------------------------------------------------------------------
// idw_table_position_correction
// Grid table position correction by inverse distance weighted blending.
//
// Items enter on in_valid/in_stall. A load item (op 0) writes one x and one y
// correction into the table and produces no result. A correct item (op 1)
// produces one result on out_valid/out_stall. A point outside the grid goes
// straight to the output; an exact hit on a cell centre skips the blending;
// a general point takes longest. The time is set by the bit-serial divider,
// which works out the cell position per axis, up to three distance ratios and
// the two final blend divisions, and by the one table port that gives the
// four cells one after another. One item is worked on at a time, so a new
// item can be taken as soon as the previous result appears, even while the
// receiver stalls it. A finished item waits while the output register is
// full and stalled. Reset returns the grid registers to their defaults and
// empties the output register; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module idw_table_position_correction (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_op,
  input  logic signed [idwtpc_pkg::POS_W-1:0]     in_rec_x,
  input  logic signed [idwtpc_pkg::POS_W-1:0]     in_rec_y,
  input  logic [idwtpc_pkg::COL_W-1:0]            in_cell_col,
  input  logic [idwtpc_pkg::ROW_W-1:0]            in_cell_row,
  input  logic signed [idwtpc_pkg::POS_W-1:0]     in_load_dx,
  input  logic signed [idwtpc_pkg::POS_W-1:0]     in_load_dy,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [idwtpc_pkg::POS_W-1:0]     out_true_x,
  output logic signed [idwtpc_pkg::POS_W-1:0]     out_true_y,
  output logic                                    out_out_of_range,
  input  logic                                    cfg_we,
  input  logic [idwtpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [idwtpc_pkg::POS_W-1:0]            cfg_data
);

  idwtpc_pkg::state_t state_r, state_nxt;

  logic signed [idwtpc_pkg::POS_W-1:0]  grid_min_r, grid_max_r;
  logic [idwtpc_pkg::CW_W-1:0]          cell_width_r, step;
  logic signed [idwtpc_pkg::POS_W-1:0]  rx_r, ry_r;
  logic [idwtpc_pkg::NUM_W-1:0]         bx0_r, by0_r;
  logic [idwtpc_pkg::CW_W-1:0]          remx_r, remy_r;
  logic [idwtpc_pkg::SQ_W-1:0]          sq_r [4];
  logic [idwtpc_pkg::DIST_W-1:0]        d_r [4];
  logic [idwtpc_pkg::DIST_W-1:0]        dmin_r;
  logic [3:0]                           inb_r;
  logic signed [idwtpc_pkg::POS_W-1:0]  cx_r [4];
  logic signed [idwtpc_pkg::POS_W-1:0]  cy_r [4];
  logic [idwtpc_pkg::WGT_W-1:0]         w_r;
  logic [idwtpc_pkg::WSUM_W-1:0]        wsum_r;
  logic signed [idwtpc_pkg::ACC_W-1:0]  numx_r, numy_r;
  logic signed [idwtpc_pkg::POS_W-1:0]  corr_x_r, corr_y_r;
  logic                                 oor_r;
  logic [2:0]                           cnt_r;
  logic signed [idwtpc_pkg::PROD_W-1:0] prod_r;
  logic                                 out_valid_r;
  logic signed [idwtpc_pkg::POS_W-1:0]  out_x_r, out_y_r;
  logic                                 out_oor_r;

  logic                                 accept, out_free, in_range;
  logic signed [idwtpc_pkg::POS_W:0]    ux_full, uy_full;
  logic signed [idwtpc_pkg::CELL_W-1:0] dx0, dy0, dx1, dy1, step2;
  logic signed [idwtpc_pkg::CELL_W-1:0] bx0e, by0e, nx, ny, cbx, cby;
  logic [1:0]                           idx, prev;
  logic                                 cell_in;
  logic signed [idwtpc_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [idwtpc_pkg::CELL_W-1:0] sq_sel;
  logic [idwtpc_pkg::ACC_W-1:0]         absx, absy, negx, negy;
  logic [idwtpc_pkg::POS_W-1:0]         q24, negq;
  logic signed [idwtpc_pkg::POS_W:0]    sumx, sumy;
  logic signed [idwtpc_pkg::POS_W-1:0]  satx, saty;

  idwtpc_pkg::div_ctl_t                 div_ctl;
  idwtpc_pkg::div_sts_t                 div_sts;
  logic [idwtpc_pkg::REM_W-1:0]         div_r_init, div_rem;
  logic [idwtpc_pkg::DIST_W-1:0]        div_den;
  logic [idwtpc_pkg::NUM_W-1:0]         div_num;
  logic [idwtpc_pkg::QUO_W-1:0]         div_quo;

  logic                                 mem_we;
  logic [idwtpc_pkg::ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [idwtpc_pkg::DATA_W-1:0]        mem_rdata;

  assign in_stall = (state_r != idwtpc_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign step     = (cell_width_r == '0) ? 23'd1 : cell_width_r;

  assign in_range = (rx_r >= grid_min_r) && (rx_r <= grid_max_r) &&
                    (ry_r >= grid_min_r) && (ry_r <= grid_max_r);
  assign ux_full  = {rx_r[idwtpc_pkg::POS_W-1], rx_r} -
                    {grid_min_r[idwtpc_pkg::POS_W-1], grid_min_r};
  assign uy_full  = {ry_r[idwtpc_pkg::POS_W-1], ry_r} -
                    {grid_min_r[idwtpc_pkg::POS_W-1], grid_min_r};

  assign step2 = $signed({2'b00, step, 1'b0});
  assign dx0   = $signed({2'b00, remx_r, 1'b0}) - $signed({3'b000, step});
  assign dy0   = $signed({2'b00, remy_r, 1'b0}) - $signed({3'b000, step});
  assign dx1   = (dx0 > 0) ? (dx0 - step2) : (dx0 + step2);
  assign dy1   = (dy0 > 0) ? (dy0 - step2) : (dy0 + step2);
  assign bx0e  = $signed({2'b00, bx0_r});
  assign by0e  = $signed({2'b00, by0_r});
  assign nx    = (dx0 > 0) ? (bx0e + 26'sd1) : (bx0e - 26'sd1);
  assign ny    = (dy0 > 0) ? (by0e + 26'sd1) : (by0e - 26'sd1);

  assign idx  = cnt_r[1:0];
  assign prev = 2'(cnt_r - 3'd1);
  assign cbx  = idx[1] ? nx : bx0e;
  assign cby  = idx[0] ? ny : by0e;
  assign cell_in = !cbx[idwtpc_pkg::CELL_W-1] && (cbx < idwtpc_pkg::GRID_COLS) &&
                   !cby[idwtpc_pkg::CELL_W-1] && (cby < idwtpc_pkg::GRID_ROWS);

  assign mem_we    = accept && (in_op == idwtpc_pkg::OP_LOAD) &&
                     (in_cell_col < idwtpc_pkg::GRID_COLS) &&
                     (in_cell_row < idwtpc_pkg::GRID_ROWS);
  assign mem_waddr = {in_cell_col, in_cell_row};
  assign mem_raddr = {cbx[idwtpc_pkg::COL_W-1:0], cby[idwtpc_pkg::ROW_W-1:0]};

  assign negx = -numx_r;
  assign negy = -numy_r;
  assign absx = numx_r[idwtpc_pkg::ACC_W-1] ? negx : numx_r;
  assign absy = numy_r[idwtpc_pkg::ACC_W-1] ? negy : numy_r;
  assign q24  = div_quo[idwtpc_pkg::POS_W-1:0];
  assign negq = -q24;

  always_comb begin
    unique case (idx)
      2'd0:    sq_sel = dx0;
      2'd1:    sq_sel = dx1;
      2'd2:    sq_sel = dy0;
      default: sq_sel = dy1;
    endcase
  end

  idwtpc_table_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_load_dx, in_load_dy}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  idwtpc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .r_init   (div_r_init),
    .den      (div_den),
    .num_init (div_num),
    .sts      (div_sts),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idwtpc_pkg::S_IDLE: begin
        if (accept && (in_op == idwtpc_pkg::OP_CORRECT)) begin
          state_nxt = idwtpc_pkg::S_RANGE;
        end
      end
      idwtpc_pkg::S_RANGE: begin
        state_nxt = in_range ? idwtpc_pkg::S_DIVX : idwtpc_pkg::S_QY_OUT;
      end
      idwtpc_pkg::S_DIVX: begin
        if (div_sts.done) begin
          state_nxt = idwtpc_pkg::S_DIVY;
        end
      end
      idwtpc_pkg::S_DIVY: begin
        if (div_sts.done) begin
          state_nxt = idwtpc_pkg::S_SQ;
        end
      end
      idwtpc_pkg::S_SQ: begin
        if (cnt_r == 3'd4) begin
          state_nxt = idwtpc_pkg::S_DSUM;
        end
      end
      idwtpc_pkg::S_DSUM: state_nxt = idwtpc_pkg::S_READ;
      idwtpc_pkg::S_READ: begin
        if (cnt_r == 3'd4) begin
          state_nxt = (d_r[0] == '0) ? idwtpc_pkg::S_QY_OUT : idwtpc_pkg::S_WSTART;
        end
      end
      idwtpc_pkg::S_WSTART: begin
        state_nxt = (d_r[idx] == dmin_r) ? idwtpc_pkg::S_MX : idwtpc_pkg::S_WDIV;
      end
      idwtpc_pkg::S_WDIV: begin
        if (div_sts.done) begin
          state_nxt = idwtpc_pkg::S_WSQ;
        end
      end
      idwtpc_pkg::S_WSQ:  state_nxt = idwtpc_pkg::S_WSQR;
      idwtpc_pkg::S_WSQR: state_nxt = idwtpc_pkg::S_MX;
      idwtpc_pkg::S_MX:   state_nxt = idwtpc_pkg::S_MY;
      idwtpc_pkg::S_MY:   state_nxt = idwtpc_pkg::S_MYR;
      idwtpc_pkg::S_MYR: begin
        state_nxt = (idx == 2'd3) ? idwtpc_pkg::S_QX : idwtpc_pkg::S_WSTART;
      end
      idwtpc_pkg::S_QX: begin
        if (div_sts.done) begin
          state_nxt = idwtpc_pkg::S_QY_OUT;
        end
      end
      idwtpc_pkg::S_QY_OUT: begin
        if ((div_sts.done || !div_sts.busy) && out_free) begin
          state_nxt = idwtpc_pkg::S_IDLE;
        end
      end
      default: state_nxt = idwtpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.iters = idwtpc_pkg::ITERS_POS;
    div_r_init    = '0;
    div_den       = {28'd0, step};
    div_num       = ux_full[idwtpc_pkg::POS_W-1:0];
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      idwtpc_pkg::S_RANGE: begin
        div_ctl.start = in_range;
      end
      idwtpc_pkg::S_DIVX: begin
        div_ctl.start = div_sts.done;
        div_num       = uy_full[idwtpc_pkg::POS_W-1:0];
      end
      idwtpc_pkg::S_SQ: begin
        mul_a = {{8{sq_sel[idwtpc_pkg::CELL_W-1]}}, sq_sel};
        mul_b = {{8{sq_sel[idwtpc_pkg::CELL_W-1]}}, sq_sel};
      end
      idwtpc_pkg::S_WSTART: begin
        div_ctl.start = (d_r[idx] != dmin_r);
        div_ctl.iters = idwtpc_pkg::ITERS_RATIO;
        div_r_init    = {1'b0, dmin_r};
        div_den       = d_r[idx];
        div_num       = '0;
      end
      idwtpc_pkg::S_WSQ: begin
        mul_a = {2'b00, div_quo};
        mul_b = {2'b00, div_quo};
      end
      idwtpc_pkg::S_MX: begin
        mul_a = {{10{cx_r[idx][idwtpc_pkg::POS_W-1]}}, cx_r[idx]};
        mul_b = {1'b0, w_r};
      end
      idwtpc_pkg::S_MY: begin
        mul_a = {{10{cy_r[idx][idwtpc_pkg::POS_W-1]}}, cy_r[idx]};
        mul_b = {1'b0, w_r};
      end
      idwtpc_pkg::S_MYR: begin
        div_ctl.start = (idx == 2'd3);
        div_r_init    = {17'd0, absx[idwtpc_pkg::ACC_W-1:idwtpc_pkg::NUM_W]};
        div_den       = {16'd0, wsum_r};
        div_num       = absx[idwtpc_pkg::NUM_W-1:0];
      end
      idwtpc_pkg::S_QX: begin
        div_ctl.start = div_sts.done;
        div_r_init    = {17'd0, absy[idwtpc_pkg::ACC_W-1:idwtpc_pkg::NUM_W]};
        div_den       = {16'd0, wsum_r};
        div_num       = absy[idwtpc_pkg::NUM_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign sumx = {rx_r[idwtpc_pkg::POS_W-1], rx_r} +
                {corr_x_r[idwtpc_pkg::POS_W-1], corr_x_r};
  assign sumy = {ry_r[idwtpc_pkg::POS_W-1], ry_r} +
                {(state_r == idwtpc_pkg::S_QY_OUT && div_sts.done) ?
                   {(numy_r[idwtpc_pkg::ACC_W-1] ? negq[idwtpc_pkg::POS_W-1] :
                     q24[idwtpc_pkg::POS_W-1]),
                    (numy_r[idwtpc_pkg::ACC_W-1] ? negq : q24)} :
                   {corr_y_r[idwtpc_pkg::POS_W-1], corr_y_r}};
  assign satx = (sumx[idwtpc_pkg::POS_W] == sumx[idwtpc_pkg::POS_W-1]) ?
                sumx[idwtpc_pkg::POS_W-1:0] :
                (sumx[idwtpc_pkg::POS_W] ? 24'sh800000 : 24'sh7FFFFF);
  assign saty = (sumy[idwtpc_pkg::POS_W] == sumy[idwtpc_pkg::POS_W-1]) ?
                sumy[idwtpc_pkg::POS_W-1:0] :
                (sumy[idwtpc_pkg::POS_W] ? 24'sh800000 : 24'sh7FFFFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= idwtpc_pkg::S_IDLE;
      grid_min_r   <= idwtpc_pkg::GRID_MIN_RST;
      grid_max_r   <= idwtpc_pkg::GRID_MAX_RST;
      cell_width_r <= idwtpc_pkg::CELL_WIDTH_RST;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          idwtpc_pkg::REG_GRID_MIN:   grid_min_r   <= cfg_data;
          idwtpc_pkg::REG_GRID_MAX:   grid_max_r   <= cfg_data;
          idwtpc_pkg::REG_CELL_WIDTH: cell_width_r <= cfg_data[idwtpc_pkg::CW_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == idwtpc_pkg::S_QY_OUT && state_nxt == idwtpc_pkg::S_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == idwtpc_pkg::S_MYR && idx != 2'd3) begin
        cnt_r <= cnt_r + 3'd1;
      end else if (!(state_r == idwtpc_pkg::S_WSTART || state_r == idwtpc_pkg::S_WDIV ||
                     state_r == idwtpc_pkg::S_WSQ || state_r == idwtpc_pkg::S_WSQR ||
                     state_r == idwtpc_pkg::S_MX || state_r == idwtpc_pkg::S_MY)) begin
        if (state_r != state_nxt) begin
          cnt_r <= '0;
        end else if (state_r == idwtpc_pkg::S_SQ || state_r == idwtpc_pkg::S_READ) begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      rx_r <= in_rec_x;
      ry_r <= in_rec_y;
    end
    unique case (state_r)
      idwtpc_pkg::S_RANGE: begin
        oor_r    <= !in_range;
        corr_x_r <= '0;
        corr_y_r <= '0;
      end
      idwtpc_pkg::S_DIVX: begin
        if (div_sts.done) begin
          bx0_r  <= div_quo[idwtpc_pkg::NUM_W-1:0];
          remx_r <= div_rem[idwtpc_pkg::CW_W-1:0];
        end
      end
      idwtpc_pkg::S_DIVY: begin
        if (div_sts.done) begin
          by0_r  <= div_quo[idwtpc_pkg::NUM_W-1:0];
          remy_r <= div_rem[idwtpc_pkg::CW_W-1:0];
        end
      end
      idwtpc_pkg::S_SQ: begin
        if (cnt_r != 3'd0) begin
          sq_r[prev] <= prod_r[idwtpc_pkg::SQ_W-1:0];
        end
      end
      idwtpc_pkg::S_DSUM: begin
        d_r[0] <= {1'b0, sq_r[0]} + {1'b0, sq_r[2]};
        d_r[1] <= {1'b0, sq_r[0]} + {1'b0, sq_r[3]};
        d_r[2] <= {1'b0, sq_r[1]} + {1'b0, sq_r[2]};
        d_r[3] <= {1'b0, sq_r[1]} + {1'b0, sq_r[3]};
      end
      idwtpc_pkg::S_READ: begin
        if (cnt_r != 3'd4) begin
          inb_r[idx] <= cell_in;
          if (cnt_r == 3'd0 || d_r[idx] < dmin_r) begin
            dmin_r <= d_r[idx];
          end
        end
        if (cnt_r != 3'd0) begin
          cx_r[prev] <= inb_r[prev] ? mem_rdata[idwtpc_pkg::DATA_W-1:idwtpc_pkg::POS_W] : '0;
          cy_r[prev] <= inb_r[prev] ? mem_rdata[idwtpc_pkg::POS_W-1:0] : '0;
        end
        if (cnt_r == 3'd4) begin
          corr_x_r <= cx_r[0];
          corr_y_r <= cy_r[0];
          wsum_r   <= '0;
          numx_r   <= '0;
          numy_r   <= '0;
        end
      end
      idwtpc_pkg::S_WSTART: begin
        w_r <= idwtpc_pkg::WGT_ONE;
      end
      idwtpc_pkg::S_WSQR: begin
        w_r <= {1'b0, prod_r[63:32]};
      end
      idwtpc_pkg::S_MX: begin
        wsum_r <= wsum_r + {2'b00, w_r};
      end
      idwtpc_pkg::S_MY: begin
        numx_r <= numx_r + $signed(prod_r[idwtpc_pkg::ACC_W-1:0]);
      end
      idwtpc_pkg::S_MYR: begin
        numy_r <= numy_r + $signed(prod_r[idwtpc_pkg::ACC_W-1:0]);
      end
      idwtpc_pkg::S_QX: begin
        if (div_sts.done) begin
          corr_x_r <= numx_r[idwtpc_pkg::ACC_W-1] ? negq : q24;
        end
      end
      idwtpc_pkg::S_QY_OUT: begin
        if (div_sts.done) begin
          corr_y_r <= numy_r[idwtpc_pkg::ACC_W-1] ? negq : q24;
        end
        if (state_nxt == idwtpc_pkg::S_IDLE) begin
          out_x_r   <= satx;
          out_y_r   <= saty;
          out_oor_r <= oor_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_true_x       = out_x_r;
  assign out_true_y       = out_y_r;
  assign out_out_of_range = out_oor_r;

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == idwtpc_pkg::S_QY_OUT))
    else $error("result appeared without finishing an item");

  a_blend_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idwtpc_pkg::S_QX) |-> (wsum_r != '0))
    else $error("blend division with zero weight sum");

  a_finish_waits_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idwtpc_pkg::S_QY_OUT && out_valid_r && out_stall)
      |=> (state_r == idwtpc_pkg::S_QY_OUT))
    else $error("finished item dropped while output register full");

endmodule
